FILE: hdl/rse_pkg.sv
package rse_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int DATA_WIDTH  = 32;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int PTR_W       = $clog2(STACK_DEPTH + 1);
  localparam int DEPTH_W     = 7;
  localparam int CNT_W       = $clog2(DATA_WIDTH + 1);

  typedef enum logic [2:0] {
    OP_PUSH = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_POW  = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNDERFLOW = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_DIV_ZERO  = 3'd3,
    ST_MALFORMED = 3'd4
  } status_t;

  // request to / response from the iterative arithmetic unit
  typedef struct packed {
    logic                  start;
    logic [2:0]            op;
    logic [DATA_WIDTH-1:0] a;
    logic [DATA_WIDTH-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic                  done;
    logic                  dz;
    logic [DATA_WIDTH-1:0] res;
  } alu_rsp_t;

endpackage

FILE: hdl/rpn_stack_evaluator_top.sv
// RPN stack evaluator. One token is a transaction on in_*; each token yields
// exactly one result transaction on out_*. Operands live in a 64-entry
// single-port-read synchronous RAM; the top two entries are read in
// consecutive cycles. Multiply and divide run one bit per cycle in the
// shared shift-add / restoring-division unit; power runs serial multiply
// and square passes per exponent bit. Errors (underflow, overflow, divide
// by zero) leave the stack unchanged; an end-of-expression token reports
// top and depth, then empties the stack. The result sits in an output
// register; a new token is taken only once it has been delivered. No
// clearing pass after reset: RAM data is used only below the stack pointer.
module rpn_stack_evaluator_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_op,
  input  logic signed [31:0]  in_value,
  input  logic                in_end_of_expression,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  out_top_value,
  output logic [6:0]          out_depth,
  output logic [2:0]          out_status,
  output logic                out_final_res
);

  localparam int W  = rse_pkg::DATA_WIDTH;
  localparam int AW = rse_pkg::ADDR_W;
  localparam int PW = rse_pkg::PTR_W;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RDB  = 7'b0000010, // top (b) arrives, read a issued
    S_RDA  = 7'b0000100, // a arrives, start unit
    S_EXE  = 7'b0001000, // top arrives for the report
    S_WAIT = 7'b0010000,
    S_TOP  = 7'b0100000, // read top (no write on this path)
    S_OUT  = 7'b1000000
  } state_t;

  state_t          st_r, st_nxt;
  logic [PW-1:0]   sp_r, sp_nxt;
  logic [2:0]      op_r, op_nxt;
  logic [W-1:0]    val_r, val_nxt;
  logic            fin_r, fin_nxt;
  logic [W-1:0]    b_r, b_nxt;
  logic [W-1:0]    top_r, top_nxt;
  logic [6:0]      dep_r, dep_nxt;
  logic [2:0]      stat_r, stat_nxt;
  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [W-1:0]    wdata, rdata;
  rse_pkg::alu_req_t req;
  rse_pkg::alu_rsp_t rsp;
  logic [PW-1:0]   sp_m1, sp_m2;

  assign sp_m1 = sp_r - PW'(1);
  assign sp_m2 = sp_r - PW'(2);

  rse_ram #(.WIDTH(W), .DEPTH(rse_pkg::STACK_DEPTH)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  rse_alu u_alu (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (req),
    .rsp  (rsp)
  );

  assign in_ready = (st_r == S_IDLE);

  always_comb begin
    st_nxt   = st_r;
    sp_nxt   = sp_r;
    op_nxt   = op_r;
    val_nxt  = val_r;
    fin_nxt  = fin_r;
    b_nxt    = b_r;
    top_nxt  = top_r;
    dep_nxt  = dep_r;
    stat_nxt = stat_r;
    we       = 1'b0;
    waddr    = sp_r[AW-1:0];
    wdata    = val_r;
    raddr    = sp_m1[AW-1:0];
    req      = '0;
    req.op   = op_r;
    req.a    = rdata;
    req.b    = b_r;
    case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt   = in_op;
          val_nxt  = in_value;
          fin_nxt  = in_end_of_expression;
          stat_nxt = rse_pkg::ST_OK;
          if (in_op == rse_pkg::OP_PUSH) begin
            if (sp_r >= PW'(rse_pkg::STACK_DEPTH)) begin
              stat_nxt = rse_pkg::ST_OVERFLOW;
              st_nxt   = S_TOP;
            end else begin
              // value known: top follows directly
              we      = 1'b1;
              wdata   = in_value;
              top_nxt = in_value;
              sp_nxt  = sp_r + PW'(1);
              st_nxt  = S_OUT;
            end
          end else if (in_op <= rse_pkg::OP_POW) begin
            if (sp_r < PW'(2)) begin
              stat_nxt = rse_pkg::ST_UNDERFLOW;
              st_nxt   = S_TOP;
            end else begin
              st_nxt = S_RDB;
            end
          end else begin
            st_nxt = S_TOP;
          end
        end
      end
      S_RDB: begin
        raddr  = sp_m2[AW-1:0];
        st_nxt = S_RDA;
        b_nxt  = rdata;
      end
      S_RDA: begin
        req.start = 1'b1;
        st_nxt    = S_WAIT;
      end
      S_WAIT: begin
        if (rsp.done) begin
          if (rsp.dz) begin
            stat_nxt = rse_pkg::ST_DIV_ZERO;
            top_nxt  = b_r;
          end else begin
            we      = 1'b1;
            waddr   = sp_m2[AW-1:0];
            wdata   = rsp.res;
            top_nxt = rsp.res;
            sp_nxt  = sp_m1;
          end
          st_nxt = S_OUT;
        end
      end
      S_TOP: st_nxt = S_EXE;
      S_EXE: begin
        top_nxt = (sp_r == '0) ? '0 : rdata;
        st_nxt  = S_OUT;
      end
      S_OUT: begin
        if (!out_valid) begin
          dep_nxt = 7'(sp_r);
          if (fin_r) begin
            if (stat_r == rse_pkg::ST_OK && sp_r != PW'(1)) begin
              stat_nxt = rse_pkg::ST_MALFORMED;
            end
            sp_nxt = '0;
          end
        end else if (out_ready) begin
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  logic ov_r, ov_nxt;
  assign ov_nxt = (st_r == S_OUT) && !(ov_r && out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      sp_r <= '0;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      sp_r <= sp_nxt;
      ov_r <= ov_nxt;
    end
    op_r   <= op_nxt;
    val_r  <= val_nxt;
    fin_r  <= fin_nxt;
    b_r    <= b_nxt;
    top_r  <= top_nxt;
    dep_r  <= dep_nxt;
    stat_r <= stat_nxt;
  end

  assign out_valid     = ov_r;
  assign out_top_value = top_r;
  assign out_depth     = dep_r;
  assign out_status    = stat_r;
  assign out_final_res = fin_r;

`ifndef ASSERT_OFF
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= PW'(rse_pkg::STACK_DEPTH))
    else $error("stack pointer beyond depth");
  a_no_take_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("token taken with result pending");
  a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_final_res) |-> (sp_r == '0))
    else $error("end token did not clear stack");
`endif

endmodule

FILE: hdl/rse_ram.sv
module rse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/rse_alu.sv
// Multi-cycle arithmetic: add/sub in one step, multiply by shift-add,
// divide by restoring long division, power by square-and-multiply
// (per exponent bit, a serial multiply pass, then a square pass if higher bits are set).
module rse_alu (
  input  logic              clk,
  input  logic              rst_n,
  input  rse_pkg::alu_req_t req,
  output rse_pkg::alu_rsp_t rsp
);

  localparam int W = rse_pkg::DATA_WIDTH;

  typedef enum logic [5:0] {
    A_IDLE = 6'b000001,
    A_MUL  = 6'b000010,
    A_DIV  = 6'b000100,
    A_PMUL = 6'b001000,
    A_PSQR = 6'b010000,
    A_DONE = 6'b100000
  } astate_t;

  astate_t              st_r, st_nxt;
  logic [W-1:0]         x_r, x_nxt;     // multiplicand / divisor mag / base
  logic [W-1:0]         y_r, y_nxt;     // multiplier / dividend / exponent
  logic [W-1:0]         acc_r, acc_nxt; // product / remainder / power partial product
  logic [W-1:0]         res_r, res_nxt;
  logic [W-1:0]         pa_r, pa_nxt;   // power: multiply operand
  logic [W-1:0]         pm_r, pm_nxt;   // power: shift-add multiplier
  logic [rse_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 neg_r, neg_nxt;
  logic                 dz_r, dz_nxt;
  logic [W-1:0]         mag_a, mag_b, rem_sh, a_w, b_w;
  logic [W:0]           trial;

  assign a_w   = req.a;
  assign b_w   = req.b;
  assign mag_a = a_w[W-1] ? (~a_w + W'(1)) : a_w;
  assign mag_b = b_w[W-1] ? (~b_w + W'(1)) : b_w;
  assign rem_sh = {acc_r[W-2:0], y_r[W-1]};
  assign trial  = {acc_r, y_r[W-1]} - {1'b0, x_r};

  always_comb begin
    st_nxt  = st_r;
    x_nxt   = x_r;
    y_nxt   = y_r;
    acc_nxt = acc_r;
    res_nxt = res_r;
    pa_nxt  = pa_r;
    pm_nxt  = pm_r;
    cnt_nxt = cnt_r;
    neg_nxt = neg_r;
    dz_nxt  = dz_r;
    case (st_r)
      A_IDLE: begin
        if (req.start) begin
          dz_nxt  = 1'b0;
          cnt_nxt = '0;
          acc_nxt = '0;
          case (req.op)
            rse_pkg::OP_ADD: begin
              res_nxt = a_w + b_w;
              st_nxt  = A_DONE;
            end
            rse_pkg::OP_SUB: begin
              res_nxt = a_w - b_w;
              st_nxt  = A_DONE;
            end
            rse_pkg::OP_MUL: begin
              x_nxt  = a_w;
              y_nxt  = b_w;
              st_nxt = A_MUL;
            end
            rse_pkg::OP_DIV: begin
              if (b_w == '0) begin
                dz_nxt = 1'b1;
                st_nxt = A_DONE;
              end else begin
                x_nxt   = mag_b;
                y_nxt   = mag_a;
                neg_nxt = a_w[W-1] ^ b_w[W-1];
                st_nxt  = A_DIV;
              end
            end
            default: begin // power
              if (b_w[W-1]) begin
                st_nxt = A_DONE;
                if (a_w == '0) dz_nxt = 1'b1;
                else if (a_w == W'(1)) res_nxt = W'(1);
                else if (a_w == '1) res_nxt = b_w[0] ? '1 : W'(1);
                else res_nxt = '0;
              end else begin
                x_nxt   = a_w;
                y_nxt   = b_w;
                res_nxt = W'(1);
                pa_nxt  = W'(1);
                pm_nxt  = a_w;
                st_nxt  = (b_w == '0) ? A_DONE : A_PMUL;
              end
            end
          endcase
        end
      end
      A_MUL: begin
        if (y_r[0]) acc_nxt = acc_r + x_r;
        x_nxt   = x_r << 1;
        y_nxt   = y_r >> 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == rse_pkg::CNT_W'(W - 1)) begin
          res_nxt = y_r[0] ? acc_r + x_r : acc_r;
          st_nxt  = A_DONE;
        end
      end
      A_DIV: begin
        if (!trial[W]) begin
          acc_nxt = trial[W-1:0];
          y_nxt   = {y_r[W-2:0], 1'b1};
        end else begin
          acc_nxt = rem_sh;
          y_nxt   = {y_r[W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == rse_pkg::CNT_W'(W - 1)) begin
          res_nxt = neg_r ? (~y_nxt + W'(1)) : y_nxt;
          st_nxt  = A_DONE;
        end
      end
      // serial multiply pa * pm, accumulated in acc; then the result
      // lands in res (if exponent bit set) or in x (squaring)
      A_PMUL, A_PSQR: begin
        if (pm_r[0]) acc_nxt = acc_r + pa_r;
        pa_nxt  = pa_r << 1;
        pm_nxt  = pm_r >> 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == rse_pkg::CNT_W'(W - 1)) begin
          cnt_nxt = '0;
          acc_nxt = '0;
          if (st_r == A_PMUL) begin
            if (y_r[0]) res_nxt = pm_r[0] ? acc_r + pa_r : acc_r;
            y_nxt  = y_r >> 1;
            st_nxt = ((y_r >> 1) == '0) ? A_DONE : A_PSQR;
            pa_nxt = x_r;
            pm_nxt = x_r;
          end else begin
            x_nxt  = pm_r[0] ? acc_r + pa_r : acc_r;
            pa_nxt = res_r;
            pm_nxt = x_nxt;
            st_nxt = A_PMUL;
          end
        end
      end
      A_DONE: st_nxt = A_IDLE;
      default: st_nxt = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= A_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    acc_r <= acc_nxt;
    res_r <= res_nxt;
    pa_r  <= pa_nxt;
    pm_r  <= pm_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
    dz_r  <= dz_nxt;
  end

  assign rsp.done = (st_r == A_DONE);
  assign rsp.dz   = dz_r;
  assign rsp.res  = res_r;

endmodule
